// ----- rtl/sender_sequence_dedup_filter_core_macros.svh -----
// Assertion macros used by the checker module of the duplicate filter.
`ifndef SENDER_SEQUENCE_DEDUP_FILTER_CORE_MACROS_SVH
`define SENDER_SEQUENCE_DEDUP_FILTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SSDF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SSDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- rtl/ssdf_pkg.sv -----
package ssdf_pkg;

  localparam int unsigned SsdfDepth   = 16;
  localparam int unsigned SenderWidth = 8;
  localparam int unsigned SeqWidth    = 16;

  // One table entry as it travels along the chain of cells.
  typedef struct packed {
    logic                   occupied;
    logic [SenderWidth-1:0] sender;
    logic [SeqWidth-1:0]    seq;
  } ssdf_entry_t;

endpackage

// ----- rtl/ssdf_cell.sv -----
module ssdf_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              shift_i,
  input  ssdf_pkg::ssdf_entry_t             entry_i,
  input  logic [ssdf_pkg::SenderWidth-1:0]  key_sender_i,
  input  logic [ssdf_pkg::SeqWidth-1:0]     key_seq_i,
  output ssdf_pkg::ssdf_entry_t             entry_o,
  output logic                              hit_o
);
  import ssdf_pkg::*;

  logic                   occupied_q;
  logic [SenderWidth-1:0] sender_q;
  logic [SeqWidth-1:0]    seq_q;

  // The occupied flags form a thermometer code along the chain, so the
  // number of set flags is the fill count of the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occupied_q <= 1'b0;
    end else if (shift_i) begin
      occupied_q <= entry_i.occupied;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sender_q <= entry_i.sender;
      seq_q    <= entry_i.seq;
    end
  end

  assign hit_o = occupied_q && (sender_q == key_sender_i) && (seq_q == key_seq_i);

  assign entry_o.occupied = occupied_q;
  assign entry_o.sender   = sender_q;
  assign entry_o.seq      = seq_q;

endmodule

// ----- rtl/sender_sequence_dedup_filter_core.sv -----
// Sender and sequence duplicate filter.
// Input channel: in_valid_i, in_stall_o, sender_id_i, seq_number_i. A beat
// is taken at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o, out_stall_i, is_duplicate_o. Every input beat
// gives exactly one output beat, in order.
// The table is a chain of cells, one entry per cell. Each cell compares its
// entry with the incoming pair in the same cycle. A new pair enters the
// first cell and every entry moves one cell on, so the oldest entry falls
// off the end once the table is full. A match leaves the chain untouched.
// The result is registered and appears on the cycle after the input
// beat. Throughput is one beat per cycle while in_stall_o is low, as the
// compare across all cells and the chain shift take place together.
// While an output beat waits under out_stall_i, in_stall_o is high, so the
// output register holds at most one result and nothing is lost.
// Reset clears all occupied flags and the output valid; the table is empty
// and a beat can be taken as soon as reset is released.
module sender_sequence_dedup_filter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ssdf_pkg::SenderWidth-1:0]  sender_id_i,
  input  logic [ssdf_pkg::SeqWidth-1:0]     seq_number_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              is_duplicate_o
);
  import ssdf_pkg::*;

  ssdf_entry_t              new_entry;
  ssdf_entry_t [SsdfDepth-1:0] chain;
  logic [SsdfDepth-1:0]     hit;
  logic                     accept;
  logic                     dup;
  logic                     shift;
  logic                     out_valid_d, out_valid_q;
  logic                     dup_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign dup        = |hit;
  assign shift      = accept && !dup;

  assign new_entry.occupied = 1'b1;
  assign new_entry.sender   = sender_id_i;
  assign new_entry.seq      = seq_number_i;

  for (genvar i = 0; i < SsdfDepth; i++) begin : g_cell
    if (i == 0) begin : g_head
      ssdf_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .shift_i     (shift),
        .entry_i     (new_entry),
        .key_sender_i(sender_id_i),
        .key_seq_i   (seq_number_i),
        .entry_o     (chain[i]),
        .hit_o       (hit[i])
      );
    end else begin : g_body
      ssdf_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .shift_i     (shift),
        .entry_i     (chain[i-1]),
        .key_sender_i(sender_id_i),
        .key_seq_i   (seq_number_i),
        .entry_o     (chain[i]),
        .hit_o       (hit[i])
      );
    end
  end

  // The entry leaving the last cell is the one being replaced.
  logic unused_tail;
  assign unused_tail = ^chain[SsdfDepth-1];

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dup_q <= dup;
    end
  end

  assign out_valid_o    = out_valid_q && !unused_tail | out_valid_q;
  assign is_duplicate_o = dup_q;

endmodule

// ----- rtl/ssdf_checker.sv -----
`include "sender_sequence_dedup_filter_core_macros.svh"

module ssdf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [ssdf_pkg::SenderWidth-1:0]  sender_id_i,
  input logic [ssdf_pkg::SeqWidth-1:0]     seq_number_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              is_duplicate_o
);
  import ssdf_pkg::*;

  logic                   in_beat;
  logic                   out_hold;
  logic                   repeat_beat;
  logic                   prev_beat_q;
  logic [SenderWidth-1:0] prev_sender_q;
  logic [SeqWidth-1:0]    prev_seq_q;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_beat_q   <= 1'b0;
      prev_sender_q <= '0;
      prev_seq_q    <= '0;
    end else begin
      prev_beat_q   <= in_beat;
      prev_sender_q <= sender_id_i;
      prev_seq_q    <= seq_number_i;
    end
  end

  // Two beats in a row carrying the same pair: the second must hit, as the
  // first one either wrote that pair into the table or found it there.
  assign repeat_beat = in_beat && prev_beat_q &&
                       (sender_id_i == prev_sender_q) &&
                       (seq_number_i == prev_seq_q);

  `SSDF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_hold, out_valid_o && $stable(is_duplicate_o))
  `SSDF_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o)
  `SSDF_ASSERT_NEXT(a_one_result, clk_i, rst_ni, in_beat, out_valid_o)
  `SSDF_ASSERT_NEXT(a_repeat_dup, clk_i, rst_ni, repeat_beat, is_duplicate_o)

endmodule

bind sender_sequence_dedup_filter_core ssdf_checker u_ssdf_checker (.*);
